### hdl/tlw_pkg.sv
// shared types, constants and step tables of the wireframe line converter
package tlw_pkg;

  localparam int unsigned PORT_WIDTH      = 32;
  localparam int unsigned INDEX_WIDTH_DEF = 32;
  localparam int unsigned GROUP_SIZE      = 6;
  localparam int unsigned TRI_SIZE        = 3;
  localparam int unsigned FILL_W          = 3;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned STEP_W          = 4;

  typedef enum logic [1:0] {
    JOB_TRI     = 2'd0,
    JOB_TWO_TRI = 2'd1,
    JOB_OUTLINE = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic      push;
    job_kind_e kind;
  } job_req_t;

  // number of line indices a job emits
  function automatic logic [STEP_W-1:0] job_len(input job_kind_e kind);
    logic [STEP_W-1:0] len;
    unique case (kind)
      JOB_TRI:     len = STEP_W'(6);
      JOB_TWO_TRI: len = STEP_W'(12);
      JOB_OUTLINE: len = STEP_W'(8);
      default:     len = STEP_W'(6);
    endcase
    return len;
  endfunction

  // edge order of one triangle: a b b c c a
  function automatic logic [SLOT_W-1:0] tri_slot(input logic [STEP_W-1:0] step);
    logic [SLOT_W-1:0] s;
    unique case (step)
      STEP_W'(0), STEP_W'(5): s = SLOT_W'(0);
      STEP_W'(1), STEP_W'(2): s = SLOT_W'(1);
      default:                s = SLOT_W'(2);
    endcase
    return s;
  endfunction

  // which gathered index goes out at a given step of a job
  function automatic logic [SLOT_W-1:0] slot_sel(input job_kind_e kind,
                                                 input logic [STEP_W-1:0] step);
    logic [SLOT_W-1:0] s;
    unique case (kind)
      JOB_TRI: s = tri_slot(step);
      JOB_TWO_TRI: begin
        if (step < STEP_W'(6)) begin
          s = tri_slot(step);
        end else begin
          s = tri_slot(step - STEP_W'(6)) + SLOT_W'(3);
        end
      end
      JOB_OUTLINE: begin
        unique case (step)
          STEP_W'(0), STEP_W'(7): s = SLOT_W'(0);
          STEP_W'(1), STEP_W'(2): s = SLOT_W'(1);
          STEP_W'(3), STEP_W'(4): s = SLOT_W'(2);
          default:                s = SLOT_W'(4);
        endcase
      end
      default: s = SLOT_W'(0);
    endcase
    return s;
  endfunction

endpackage

### hdl/tlw_front.sv
// front end: gathers list indices, classifies groups and issues emit jobs
module tlw_front #(
  parameter int unsigned INDEX_WIDTH = tlw_pkg::INDEX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [INDEX_WIDTH-1:0]       vertex_index_i,
  input  logic                         list_end_i,
  output tlw_pkg::job_req_t            job_o,
  output logic [5:0][INDEX_WIDTH-1:0]  slots_o
);
  import tlw_pkg::*;

  logic [5:0][INDEX_WIDTH-1:0] group_q;
  logic [FILL_W-1:0]           fill_q, fill_d, fill_n;
  logic                        tri_mode_q, tri_mode_d;
  logic                        first_q, first_d;
  logic [5:0][INDEX_WIDTH-1:0] cur;
  logic                        is_quad;
  logic                        hit;
  job_kind_e                   kind;

  // gathered group with the incoming index in its place
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cur[k] = (fill_q == FILL_W'(k)) ? vertex_index_i : group_q[k];
    end
  end

  assign is_quad = (cur[1] == cur[0] + INDEX_WIDTH'(1)) &&
                   (cur[3] == cur[2]) &&
                   (cur[4] == cur[3] - INDEX_WIDTH'(1)) &&
                   (cur[5] == cur[0]);

  assign fill_n = fill_q + FILL_W'(1);

  always_comb begin
    hit        = 1'b0;
    kind       = JOB_TRI;
    fill_d     = fill_q;
    tri_mode_d = tri_mode_q;
    first_d    = first_q;
    if (accept_i) begin
      fill_d = fill_n;
      if (tri_mode_q) begin
        if (fill_n == FILL_W'(TRI_SIZE)) begin
          hit    = 1'b1;
          fill_d = '0;
        end
      end else if (fill_n == FILL_W'(GROUP_SIZE)) begin
        hit     = 1'b1;
        fill_d  = '0;
        first_d = 1'b0;
        if (first_q && list_end_i) begin
          kind = JOB_TWO_TRI;
        end else if (is_quad) begin
          kind = JOB_OUTLINE;
        end else begin
          kind       = JOB_TWO_TRI;
          tri_mode_d = 1'b1;
        end
      end else if (list_end_i && fill_n >= FILL_W'(TRI_SIZE)) begin
        hit = 1'b1;
      end
      if (list_end_i) begin
        fill_d     = '0;
        tri_mode_d = 1'b0;
        first_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      tri_mode_q <= 1'b0;
      first_q    <= 1'b1;
    end else begin
      fill_q     <= fill_d;
      tri_mode_q <= tri_mode_d;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      group_q <= cur;
    end
  end

  assign job_o.push = hit;
  assign job_o.kind = kind;
  assign slots_o    = cur;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(GROUP_SIZE))
    else $error("group fill beyond six");

  a_tri_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_mode_q |-> fill_q < FILL_W'(TRI_SIZE))
    else $error("triangle mode holds more than a partial triple");

endmodule

### hdl/tlw_job_fifo.sv
// two-entry job queue between front end and emitter
module tlw_job_fifo #(
  parameter int unsigned INDEX_WIDTH = tlw_pkg::INDEX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlw_pkg::job_req_t            job_i,
  input  logic [5:0][INDEX_WIDTH-1:0]  slots_i,
  input  logic                         pop_i,
  output logic                         full_o,
  output logic                         empty_o,
  output tlw_pkg::job_kind_e           kind_o,
  output logic [5:0][INDEX_WIDTH-1:0]  slots_o
);
  import tlw_pkg::*;

  job_kind_e                   kind_q [2];
  logic [5:0][INDEX_WIDTH-1:0] slot_q [2];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [1:0]                  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign kind_o  = kind_q[rd_ptr_q];
  assign slots_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (job_i.push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)      rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(job_i.push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.push) begin
      kind_q[wr_ptr_q] <= job_i.kind;
      slot_q[wr_ptr_q] <= slots_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_i.push && full_o))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("job popped from empty queue");

endmodule

### hdl/tlw_back.sv
// emitter: walks a job one line index per cycle into the output register while it is empty or popped
module tlw_back #(
  parameter int unsigned INDEX_WIDTH = tlw_pkg::INDEX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_empty_i,
  input  tlw_pkg::job_kind_e           kind_i,
  input  logic [5:0][INDEX_WIDTH-1:0]  slots_i,
  output logic                         job_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [INDEX_WIDTH-1:0]       line_index_o,
  output logic                         run_last_o
);
  import tlw_pkg::*;

  logic [STEP_W-1:0]      step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic [INDEX_WIDTH-1:0] out_idx_q;
  logic                   out_last_q;
  logic                   advance, last;
  logic [SLOT_W-1:0]      sel;

  assign advance = !job_empty_i && (!out_valid_q || pop_i);
  assign last    = (step_q == job_len(kind_i) - STEP_W'(1));
  assign sel     = slot_sel(kind_i, step_q);

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && !pop_i;
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = last ? '0 : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_idx_q  <= slots_i[sel];
      out_last_q <= last;
    end
  end

  assign job_pop_o    = advance && last;
  assign empty_o      = !out_valid_q;
  assign line_index_o = out_idx_q;
  assign run_last_o   = out_last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> step_q < job_len(kind_i))
    else $error("emit step past end of job");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_empty_i |-> step_q == '0)
    else $error("emit step left mid-job with no job queued");

endmodule

### hdl/triangle_list_to_wireframe_lines.sv
// top level of the triangle-list to wireframe line-list converter
//
//  channel   | direction | handshake          | beat fields
//  ----------+-----------+--------------------+--------------------------
//  index in  | input     | push / full        | vertex_index_i, list_end_i
//  lines out | output    | empty / pop        | line_index_o, run_last_o
//
// the front end takes one index beat per cycle while the job queue has room;
// a finished triangle, triangle pair or quad outline becomes one queued job
// the emitter sends one line index per cycle while the output register is empty or popped;
// a triangle job gives six line indices, a pair twelve and a quad outline eight
// reset clears the counters, state flags and queue pointers only; there is no clearing pass
// full rises with two jobs queued; a stalled pop holds the output register
module triangle_list_to_wireframe_lines #(
  parameter int unsigned INDEX_WIDTH = tlw_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [tlw_pkg::PORT_WIDTH-1:0]    vertex_index_i,
  input  logic                              list_end_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [tlw_pkg::PORT_WIDTH-1:0]    line_index_o,
  output logic                              run_last_o
);
  import tlw_pkg::*;

  logic                        accept;
  job_req_t                    job;
  logic [5:0][INDEX_WIDTH-1:0] front_slots;
  logic [5:0][INDEX_WIDTH-1:0] head_slots;
  job_kind_e                   head_kind;
  logic                        q_full, q_empty, q_pop;
  logic [INDEX_WIDTH-1:0]      line_idx;

  // an index beat lands only while the queue can take a job
  assign full   = q_full;
  assign accept = push && !q_full;

  tlw_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .vertex_index_i (vertex_index_i[INDEX_WIDTH-1:0]),
    .list_end_i     (list_end_i),
    .job_o          (job),
    .slots_o        (front_slots)
  );

  // decouples classification from emission
  tlw_job_fifo #(.INDEX_WIDTH(INDEX_WIDTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job),
    .slots_i (front_slots),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .kind_o  (head_kind),
    .slots_o (head_slots)
  );

  tlw_back #(.INDEX_WIDTH(INDEX_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (q_empty),
    .kind_i       (head_kind),
    .slots_i      (head_slots),
    .job_pop_o    (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .line_index_o (line_idx),
    .run_last_o   (run_last_o)
  );

  // indices narrower than the port are zero-extended
  assign line_index_o = PORT_WIDTH'(line_idx);

endmodule
